// ----- rtl/fsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants for the Forth stack ALU.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int DataDepthDef   = 32;
  localparam int ReturnDepthDef = 16;
  localparam int CellBitsDef    = 32;

  typedef enum logic [4:0] {
    F_LIT = 5'd0, F_DUP = 5'd1, F_DROP = 5'd2, F_SWAP = 5'd3, F_OVER = 5'd4,
    F_ADD = 5'd5, F_SUB = 5'd6, F_MUL = 5'd7, F_DIVMOD = 5'd8, F_AND = 5'd9,
    F_OR = 5'd10, F_XOR = 5'd11, F_INVERT = 5'd12, F_NEGATE = 5'd13,
    F_LSHIFT = 5'd14, F_RSHIFT = 5'd15, F_LT = 5'd16, F_LE = 5'd17,
    F_GT = 5'd18, F_GE = 5'd19, F_ZERO = 5'd20, F_TOR = 5'd21,
    F_FROMR = 5'd22, F_RFETCH = 5'd23, F_RESTART = 5'd24
  } func_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DUNDER = 3'd1, ST_DOVER = 3'd2, ST_RUNDER = 3'd3,
    ST_ROVER = 3'd4, ST_DIVZ = 3'd5
  } status_e;

  // stack cell move command
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0, SH_PUSH = 2'd1, SH_POP = 2'd2
  } shift_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0, S_MUL = 2'd1, S_DIV = 2'd2, S_OUT = 2'd3
  } state_e;

endpackage

// ----- rtl/fsa_if.sv -----
// ----------------------------------------------------------------------------
// fsa_in_if / fsa_out_if
// Valid/ready channels for instructions and results.
// ----------------------------------------------------------------------------
interface fsa_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  func;
  logic signed [31:0] push_value;
  modport source (output valid, func, push_value, input ready);
  modport sink (input valid, func, push_value, output ready);
endinterface

interface fsa_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] top_value;
  logic signed [31:0] second_value;
  logic [5:0]  data_depth;
  logic [4:0]  return_depth;
  logic [2:0]  status;
  modport source (output valid, top_value, second_value, data_depth, return_depth,
                  status, input ready);
  modport sink (input valid, top_value, second_value, data_depth, return_depth,
                status, output ready);
endinterface

// ----- rtl/fsa_cell.sv -----
// ----------------------------------------------------------------------------
// fsa_cell
// One stack cell: holds, takes the cell above on push, the cell below on pop.
// ----------------------------------------------------------------------------
module fsa_cell
  import fsa_pkg::*;
#(
  parameter int CellBits = CellBitsDef
) (
  input  logic                clk_i,
  input  shift_e              shift_i,
  input  logic [CellBits-1:0] above_i,
  input  logic [CellBits-1:0] below_i,
  output logic [CellBits-1:0] value_o
);

  logic [CellBits-1:0] value_q;

  always_ff @(posedge clk_i) begin
    case (shift_i)
      SH_PUSH: value_q <= above_i;
      SH_POP:  value_q <= below_i;
      default: value_q <= value_q;
    endcase
  end

  assign value_o = value_q;

endmodule

// ----- rtl/fsa_stack.sv -----
// ----------------------------------------------------------------------------
// fsa_stack
// Stack built from a chain of cells; entry 0 is the top, fed by new_i on push.
// The top two entries can also be overwritten in place.
// ----------------------------------------------------------------------------
module fsa_stack
  import fsa_pkg::*;
#(
  parameter int Depth    = DataDepthDef,
  parameter int CellBits = CellBitsDef
) (
  input  logic                clk_i,
  input  shift_e              shift_i,
  input  logic [CellBits-1:0] new_i,
  input  logic                wr_top_i,
  input  logic [CellBits-1:0] top_i,
  input  logic                wr_sec_i,
  input  logic [CellBits-1:0] sec_i,
  output logic [CellBits-1:0] top_o,
  output logic [CellBits-1:0] sec_o
);

  logic [CellBits-1:0] val [Depth];
  logic [CellBits-1:0] abv [Depth];
  logic [CellBits-1:0] blw [Depth];
  shift_e              sh  [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    always_comb begin
      sh[i]  = shift_i;
      abv[i] = (i == 0) ? new_i : val[(i == 0) ? 0 : i-1];
      blw[i] = (i == Depth-1) ? val[i] : val[(i == Depth-1) ? i : i+1];
      if (i == 0 && wr_top_i) begin
        sh[i] = SH_PUSH; abv[i] = top_i;
      end
      if (i == 1 && wr_sec_i) begin
        sh[i] = SH_PUSH; abv[i] = sec_i;
      end
    end
    fsa_cell #(.CellBits(CellBits)) u_cell (
      .clk_i, .shift_i(sh[i]), .above_i(abv[i]), .below_i(blw[i]), .value_o(val[i])
    );
  end

  assign top_o = val[0];
  assign sec_o = val[1];

endmodule

// ----- rtl/fsa_divider.sv -----
// ----------------------------------------------------------------------------
// fsa_divider
// Restoring signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsa_divider
  import fsa_pkg::*;
#(
  parameter int CellBits = CellBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CellBits-1:0] num_i,
  input  logic [CellBits-1:0] den_i,
  output logic                done_o,
  output logic [CellBits-1:0] quo_o,
  output logic [CellBits-1:0] rem_o
);

  localparam int CntW = $clog2(CellBits + 1);

  logic [CellBits-1:0] q_q, q_d, r_q, r_d, d_q, d_d;
  logic                nq_q, nq_d, nr_q, nr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [CellBits:0]   trial;
  logic [CellBits-1:0] ma, mb;

  always_comb begin
    ma = num_i[CellBits-1] ? -num_i : num_i;
    mb = den_i[CellBits-1] ? -den_i : den_i;
    q_d = q_q; r_d = r_q; d_d = d_q; nq_d = nq_q; nr_d = nr_q;
    cnt_d = cnt_q; busy_d = busy_q;
    trial = {r_q, q_q[CellBits-1]} - {1'b0, d_q};
    if (start_i) begin
      q_d = ma; r_d = '0; d_d = mb; cnt_d = CntW'(CellBits); busy_d = 1'b1;
      nq_d = num_i[CellBits-1] ^ den_i[CellBits-1];
      nr_d = num_i[CellBits-1];
    end else if (busy_q) begin
      if (trial[CellBits]) begin
        r_d = {r_q[CellBits-2:0], q_q[CellBits-1]};
        q_d = {q_q[CellBits-2:0], 1'b0};
      end else begin
        r_d = trial[CellBits-1:0];
        q_d = {q_q[CellBits-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d; nq_q <= nq_d; nr_q <= nr_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o  = nq_q ? -q_d : q_d;
  assign rem_o  = nr_q ? -r_d : r_d;

endmodule

// ----- rtl/forth_stack_alu_unit.sv -----
// ----------------------------------------------------------------------------
// forth_stack_alu_unit
// Primitives go from S_IDLE to S_OUT; mul passes through S_MUL and divmod
// through S_DIV (the bit-serial divider) on the way. One primitive at a time;
// the result register frees the input as soon as it is taken.
// Reset: both depths clear at once; stack cells are undefined until written.
// ----------------------------------------------------------------------------
module forth_stack_alu_unit
  import fsa_pkg::*;
#(
  parameter int DATA_DEPTH   = DataDepthDef,
  parameter int RETURN_DEPTH = ReturnDepthDef,
  parameter int CELL_BITS    = CellBitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  fsa_in_if.sink    in_if,
  fsa_out_if.source out_if
);

  localparam int DW = $clog2(DATA_DEPTH + 1);
  localparam int RW = $clog2(RETURN_DEPTH + 1);
  localparam int SW = $clog2(CELL_BITS);

  state_e state_q, state_d;
  logic [DW-1:0] dc_q, dc_d;
  logic [RW-1:0] rc_q, rc_d;
  logic [2:0]    st_q, st_d;
  logic          ov_q, ov_d;

  shift_e dsh, rsh;
  logic [CELL_BITS-1:0] dnew, dtop, dsec, rtop, wtop, wsec;
  logic                 wr_top, wr_sec;
  logic [CELL_BITS-1:0] lit, res;
  logic [CELL_BITS-1:0] mul_q;
  logic                 div_start, div_done;
  logic [CELL_BITS-1:0] quo, rem;
  logic                 lt, gt, big;
  logic [4:0]           f;
  logic                 accept;

  assign f      = in_if.func;
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && (!ov_q || out_if.ready);

  // literal into cell width
  always_comb begin
    lit = CELL_BITS'(in_if.push_value);
    if (CELL_BITS > 32) lit = CELL_BITS'($signed(in_if.push_value));
  end

  assign lt  = $signed(dsec) < $signed(dtop);
  assign gt  = $signed(dsec) > $signed(dtop);
  assign big = (dtop >= CELL_BITS'(CELL_BITS));

  always_comb begin
    case (f)
      F_ADD:    res = dsec + dtop;
      F_SUB:    res = dsec - dtop;
      F_AND:    res = dsec & dtop;
      F_OR:     res = dsec | dtop;
      F_XOR:    res = dsec ^ dtop;
      F_LSHIFT: res = big ? '0 : dsec << dtop[SW-1:0];
      F_RSHIFT: res = big ? {CELL_BITS{dsec[CELL_BITS-1]}}
                          : CELL_BITS'($signed(dsec) >>> dtop[SW-1:0]);
      F_LT:     res = CELL_BITS'(lt);
      F_LE:     res = CELL_BITS'(!gt);
      F_GT:     res = CELL_BITS'(gt);
      F_GE:     res = CELL_BITS'(!lt);
      default:  res = '0;
    endcase
  end

  always_ff @(posedge clk_i) mul_q <= dsec * dtop;

  always_comb begin
    state_d = state_q; dc_d = dc_q; rc_d = rc_q; st_d = st_q;
    dsh = SH_HOLD; rsh = SH_HOLD; dnew = lit;
    wr_top = 1'b0; wtop = res; wr_sec = 1'b0; wsec = quo;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: if (accept) begin
        st_d = ST_OK; state_d = S_OUT;
        case (f)
          F_LIT: if (dc_q >= DW'(DATA_DEPTH)) st_d = ST_DOVER;
                 else begin dsh = SH_PUSH; dc_d = dc_q + 1'b1; end
          F_DUP, F_OVER:
            if (dc_q < ((f == F_DUP) ? DW'(1) : DW'(2))) st_d = ST_DUNDER;
            else if (dc_q >= DW'(DATA_DEPTH)) st_d = ST_DOVER;
            else begin
              dsh = SH_PUSH; dnew = (f == F_DUP) ? dtop : dsec; dc_d = dc_q + 1'b1;
            end
          F_DROP: if (dc_q < DW'(1)) st_d = ST_DUNDER;
                  else begin dsh = SH_POP; dc_d = dc_q - 1'b1; end
          F_SWAP: if (dc_q < DW'(2)) st_d = ST_DUNDER;
                  else begin wr_top = 1'b1; wtop = dsec; wr_sec = 1'b1; wsec = dtop; end
          F_MUL: if (dc_q < DW'(2)) st_d = ST_DUNDER;
                 else state_d = S_MUL;
          F_DIVMOD: if (dc_q < DW'(2)) st_d = ST_DUNDER;
                    else if (dtop == '0) st_d = ST_DIVZ;
                    else begin div_start = 1'b1; state_d = S_DIV; end
          F_ADD, F_SUB, F_AND, F_OR, F_XOR, F_LSHIFT, F_RSHIFT,
          F_LT, F_LE, F_GT, F_GE:
            if (dc_q < DW'(2)) st_d = ST_DUNDER;
            else begin
              dsh = SH_POP; wr_top = 1'b1; dc_d = dc_q - 1'b1;
            end
          F_INVERT, F_NEGATE, F_ZERO:
            if (dc_q < DW'(1)) st_d = ST_DUNDER;
            else begin
              wr_top = 1'b1;
              wtop = (f == F_INVERT) ? ~dtop : (f == F_NEGATE) ? -dtop
                   : ((dtop == '0) ? '1 : '0);
            end
          F_TOR: if (dc_q < DW'(1)) st_d = ST_DUNDER;
                 else if (rc_q >= RW'(RETURN_DEPTH)) st_d = ST_ROVER;
                 else begin
                   rsh = SH_PUSH; dsh = SH_POP;
                   rc_d = rc_q + 1'b1; dc_d = dc_q - 1'b1;
                 end
          F_FROMR, F_RFETCH:
            if (dc_q >= DW'(DATA_DEPTH)) st_d = ST_DOVER;
            else if (rc_q < RW'(1)) st_d = ST_RUNDER;
            else begin
              dsh = SH_PUSH; dnew = rtop; dc_d = dc_q + 1'b1;
              if (f == F_FROMR) begin rsh = SH_POP; rc_d = rc_q - 1'b1; end
            end
          F_RESTART: begin dc_d = '0; rc_d = '0; end
          default: ;
        endcase
      end
      S_MUL: begin
        // pop then overwrite new top with the product
        dsh = SH_POP; wr_top = 1'b1; wtop = mul_q; dc_d = dc_q - 1'b1;
        state_d = S_OUT;
      end
      S_DIV: if (div_done) begin
        wr_top = 1'b1; wtop = quo; wr_sec = 1'b1; wsec = rem; state_d = S_OUT;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_OUT) state_d = S_IDLE;
  end

  // result register
  always_comb begin
    ov_d = ov_q;
    if (out_if.valid && out_if.ready) ov_d = 1'b0;
    if (state_q == S_OUT) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; dc_q <= '0; rc_q <= '0; st_q <= ST_OK; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; dc_q <= dc_d; rc_q <= rc_d; st_q <= st_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT) begin
      out_if.top_value    <= (dc_q >= DW'(1)) ? 32'($signed(dtop)) : '0;
      out_if.second_value <= (dc_q >= DW'(2)) ? 32'($signed(dsec)) : '0;
      out_if.data_depth   <= 6'(dc_q);
      out_if.return_depth <= 5'(rc_q);
      out_if.status       <= st_q;
    end
  end
  assign out_if.valid = ov_q;

  fsa_stack #(.Depth(DATA_DEPTH), .CellBits(CELL_BITS)) u_dstack (
    .clk_i, .shift_i(dsh), .new_i(dnew), .wr_top_i(wr_top), .top_i(wtop),
    .wr_sec_i(wr_sec), .sec_i(wsec), .top_o(dtop), .sec_o(dsec)
  );

  logic [CELL_BITS-1:0] rsec_unused;
  fsa_stack #(.Depth(RETURN_DEPTH), .CellBits(CELL_BITS)) u_rstack (
    .clk_i, .shift_i(rsh), .new_i(dtop), .wr_top_i(1'b0), .top_i(dtop),
    .wr_sec_i(1'b0), .sec_i(dtop), .top_o(rtop), .sec_o(rsec_unused)
  );

  fsa_divider #(.CellBits(CELL_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(dsec), .den_i(dtop),
    .done_o(div_done), .quo_o(quo), .rem_o(rem)
  );

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_q <= DW'(DATA_DEPTH)) else $error("data depth past limit");
  a_rdepth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= RW'(RETURN_DEPTH)) else $error("return depth past limit");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !accept) |=> $stable(dc_q) && $stable(rc_q))
    else $error("depth moved while idle");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_if.ready) else $error("ready while busy");

endmodule
